// ===== rtl/sspq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sspq_pkg
// Shared types and operation codes for the stable sorted priority queue.
// ---------------------------------------------------------------------------
package sspq_pkg;

    // operation codes carried on the kind port
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef logic signed [31:0] word_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic  enq;      // insert, already gated with not-full
        logic  deq;      // remove head, already gated with not-empty
        word_t value;
        word_t weight;
    } cmd_t;

endpackage

// ===== rtl/stable_sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded priority queue kept in ascending weight order in a chain of
// cells; equal weights leave in arrival order.
// ---------------------------------------------------------------------------
//  channel   handshake        word
//  -------   --------------   ------------------------------------------
//  command   start / busy     kind, item_value, item_weight
//  result    done (strobe)    removed_valid, removed_value, removed_weight,
//                             dropped, occupancy, front_value
//
//  One command per cycle; its result strobes on done in the following cycle.
//  Every cell compares its weight with the new item in parallel, so the
//  insert or removal finishes in one pass of the chain; busy stays low.
//  rst_n clears the entry count; the cell payload is not reset.
//  The receiver cannot stall: each result is valid only while done is high.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  sspq_pkg::word_t      item_value,
    input  sspq_pkg::word_t      item_weight,
    output logic                 done,
    output logic                 removed_valid,
    output sspq_pkg::word_t      removed_value,
    output sspq_pkg::word_t      removed_weight,
    output logic                 dropped,
    output logic [4:0]           occupancy,
    output sspq_pkg::word_t      front_value
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             done_reg;
    logic             removed_valid_reg;
    sspq_pkg::word_t  removed_value_reg;
    sspq_pkg::word_t  removed_weight_reg;
    logic             dropped_reg;

    logic             accept;
    logic             full;
    logic             empty;
    sspq_pkg::cmd_t   cmd;

    logic             cell_cond   [CAPACITY];
    sspq_pkg::word_t  cell_value  [CAPACITY];
    sspq_pkg::word_t  cell_weight [CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    // command broadcast to the chain
    always_comb
    begin
        cmd.enq    = accept && (kind == sspq_pkg::KIND_ENQ) && !full;
        cmd.deq    = accept && (kind == sspq_pkg::KIND_DEQ) && !empty;
        cmd.value  = item_value;
        cmd.weight = item_weight;
    end

    // chain of cells, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic            occ;
        logic            lc;
        sspq_pkg::word_t lv;
        sspq_pkg::word_t lw;
        sspq_pkg::word_t rv;
        sspq_pkg::word_t rw;

        assign occ = (count_reg > CW'(i));

        if (i == 0)
        begin : g_head
            assign lc = 1'b0;
            assign lv = item_value;
            assign lw = item_weight;
        end
        else
        begin : g_mid
            assign lc = cell_cond[i-1];
            assign lv = cell_value[i-1];
            assign lw = cell_weight[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign rv = '0;
            assign rw = '0;
        end
        else
        begin : g_next
            assign rv = cell_value[i+1];
            assign rw = cell_weight[i+1];
        end

        sspq_cell u_cell (
            .clk          (clk),
            .cmd          (cmd),
            .occupied     (occ),
            .left_cond    (lc),
            .left_value   (lv),
            .left_weight  (lw),
            .right_value  (rv),
            .right_weight (rw),
            .cond         (cell_cond[i]),
            .value        (cell_value[i]),
            .weight       (cell_weight[i])
        );
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            done_reg          <= 1'b0;
            removed_valid_reg <= 1'b0;
            dropped_reg       <= 1'b0;
        end
        else
        begin
            count_reg         <= count_next;
            done_reg          <= accept;
            removed_valid_reg <= cmd.deq;
            dropped_reg       <= accept && (kind == sspq_pkg::KIND_ENQ) && full;
        end
    end

    // removed pair captured from the head
    always_ff @(posedge clk)
    begin
        removed_value_reg  <= cmd.deq ? cell_value[0]  : '0;
        removed_weight_reg <= cmd.deq ? cell_weight[0] : '0;
    end

    // result word; count and head already reflect the operation
    assign done           = done_reg;
    assign removed_valid  = removed_valid_reg;
    assign removed_value  = removed_value_reg;
    assign removed_weight = removed_weight_reg;
    assign dropped        = dropped_reg;
    assign occupancy      = 5'(count_reg);
    assign front_value    = empty ? '0 : cell_value[0];

`ifndef SYNTH
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_done_follows : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command gave no result");

    a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
        (done && dropped) |-> (full && !removed_valid))
        else $error("drop reported while not full");

    a_remove_count : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("removal did not lower the count");
`endif

endmodule

// ===== rtl/sspq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain. Holds a value/weight pair and, each
// cycle, keeps it, takes the left neighbor's pair, takes the new item,
// or takes the right neighbor's pair.
// ---------------------------------------------------------------------------
module sspq_cell (
    input  logic                 clk,
    input  sspq_pkg::cmd_t       cmd,
    input  logic                 occupied,
    input  logic                 left_cond,
    input  sspq_pkg::word_t      left_value,
    input  sspq_pkg::word_t      left_weight,
    input  sspq_pkg::word_t      right_value,
    input  sspq_pkg::word_t      right_weight,
    output logic                 cond,
    output sspq_pkg::word_t      value,
    output sspq_pkg::word_t      weight
);

    sspq_pkg::word_t value_reg;
    sspq_pkg::word_t value_next;
    sspq_pkg::word_t weight_reg;
    sspq_pkg::word_t weight_next;

    // new item belongs at or before this slot: slot empty or strictly heavier
    assign cond = !occupied || (weight_reg > cmd.weight);

    // slot update: shift right on insert, shift left on remove
    always_comb
    begin
        value_next  = value_reg;
        weight_next = weight_reg;
        if (cmd.enq && cond)
        begin
            if (left_cond)
            begin
                value_next  = left_value;
                weight_next = left_weight;
            end
            else
            begin
                value_next  = cmd.value;
                weight_next = cmd.weight;
            end
        end
        else if (cmd.deq)
        begin
            value_next  = right_value;
            weight_next = right_weight;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        weight_reg <= weight_next;
    end

    assign value  = value_reg;
    assign weight = weight_reg;

endmodule

// ===== tb/sv/stable_sorted_priority_queue_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_sorted_priority_queue_unit_test
// Self-checking bench for the stable sorted priority queue. A queue-fed
// driver issues enqueue and dequeue words with random hold-offs. A shadow
// copy of the sorted list predicts every result word, and the monitor checks
// each strobed result field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module stable_sorted_priority_queue_unit_test;

    localparam int CAPACITY = 16;

    // one command word plus the idle cycles that precede it
    typedef struct {
        logic            kind;
        sspq_pkg::word_t value;
        sspq_pkg::word_t weight;
        int              gap;
    } queue_cmd_t;

    // one result word as the block should report it
    typedef struct {
        logic            removed_valid;
        sspq_pkg::word_t removed_value;
        sspq_pkg::word_t removed_weight;
        logic            dropped;
        logic [4:0]      occupancy;
        sspq_pkg::word_t front_value;
    } queue_outcome_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            kind = sspq_pkg::KIND_ENQ;
    sspq_pkg::word_t item_value = '0;
    sspq_pkg::word_t item_weight = '0;
    logic            busy;
    logic            done;
    logic            removed_valid;
    sspq_pkg::word_t removed_value;
    sspq_pkg::word_t removed_weight;
    logic            dropped;
    logic [4:0]      occupancy;
    sspq_pkg::word_t front_value;

    queue_cmd_t     commands_pending[$];
    queue_outcome_t outcomes_due[$];

    // shadow of the sorted list, head at index 0
    sspq_pkg::word_t shadow_value[CAPACITY];
    sspq_pkg::word_t shadow_weight[CAPACITY];
    int              shadow_count = 0;

    int failures = 0;
    int results_checked = 0;
    int n_enq = 0;
    int n_drop = 0;
    int n_deq = 0;
    int n_empty_deq = 0;
    int peak_count = 0;

    // driver state
    queue_cmd_t staged;
    logic       staged_valid = 1'b0;
    int         hold_off = 0;

    stable_sorted_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .item_value(item_value),
        .item_weight(item_weight),
        .done(done),
        .removed_valid(removed_valid),
        .removed_value(removed_value),
        .removed_weight(removed_weight),
        .dropped(dropped),
        .occupancy(occupancy),
        .front_value(front_value)
    );

    always #5 clk = ~clk;

    // apply one command to the shadow list and return the expected word
    function automatic queue_outcome_t apply_to_shadow(input logic op,
                                                       input sspq_pkg::word_t v,
                                                       input sspq_pkg::word_t w);
        queue_outcome_t res;
        int pos;
        res = '{1'b0, '0, '0, 1'b0, '0, '0};
        if (op == sspq_pkg::KIND_ENQ)
        begin
            n_enq++;
            if (shadow_count >= CAPACITY)
            begin
                res.dropped = 1'b1;
                n_drop++;
            end
            else
            begin
                // stable insert: after every entry with weight <= w
                pos = 0;
                while (pos < shadow_count && shadow_weight[pos] <= w)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_value[i]  = shadow_value[i - 1];
                    shadow_weight[i] = shadow_weight[i - 1];
                end
                shadow_value[pos]  = v;
                shadow_weight[pos] = w;
                shadow_count++;
                if (shadow_count > peak_count)
                    peak_count = shadow_count;
            end
        end
        else
        begin
            n_deq++;
            if (shadow_count == 0)
                n_empty_deq++;
            else
            begin
                res.removed_valid  = 1'b1;
                res.removed_value  = shadow_value[0];
                res.removed_weight = shadow_weight[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_value[i - 1]  = shadow_value[i];
                    shadow_weight[i - 1] = shadow_weight[i];
                end
                shadow_count--;
            end
        end
        res.occupancy   = 5'(shadow_count);
        res.front_value = (shadow_count > 0) ? shadow_value[0] : '0;
        return res;
    endfunction

    task automatic add_cmd(input logic op, input sspq_pkg::word_t v,
                           input sspq_pkg::word_t w, input int gap);
        commands_pending.push_back('{op, v, w, gap});
    endtask

    task automatic check_field(input string name, input sspq_pkg::word_t want,
                               input sspq_pkg::word_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // driver: present the next word once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            staged_valid = 1'b0;
            hold_off     = 0;
        end
        else if (!start || !busy)
        begin
            if (!staged_valid && commands_pending.size() > 0)
            begin
                staged       = commands_pending.pop_front();
                staged_valid = 1'b1;
                hold_off     = staged.gap;
            end
            if (staged_valid && hold_off == 0)
            begin
                start        <= 1'b1;
                kind         <= staged.kind;
                item_value   <= staged.value;
                item_weight  <= staged.weight;
                staged_valid = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                if (hold_off > 0)
                    hold_off--;
            end
        end
    end

    // monitor: predict on acceptance, check on the done strobe
    always @(posedge clk)
    begin : result_check
        queue_outcome_t want;
        if (rst_n)
        begin
            if (start && !busy)
                outcomes_due.push_back(apply_to_shadow(kind, item_value, item_weight));
            if (done)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("removed_valid", 32'(want.removed_valid),
                                32'(removed_valid));
                    check_field("removed_value", want.removed_value, removed_value);
                    check_field("removed_weight", want.removed_weight, removed_weight);
                    check_field("dropped", 32'(want.dropped), 32'(dropped));
                    check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
                    check_field("front_value", want.front_value, front_value);
                    results_checked++;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int generated;
        int burst_len;
        int enq_pct;
        int idle_mode;
        int gap;
        sspq_pkg::word_t w;

        // dequeue on empty, garbage in the ignored fields
        add_cmd(sspq_pkg::KIND_DEQ, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        // fill to capacity with extremes, ties at head, middle and tail
        add_cmd(sspq_pkg::KIND_ENQ, 1, 0, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 32'h8000_0000, 32'h8000_0000, $urandom_range(0, 17));
        add_cmd(sspq_pkg::KIND_ENQ, -1, -1, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 2, 0, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 3, 7, $urandom_range(0, 17));
        add_cmd(sspq_pkg::KIND_ENQ, 4, 7, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 5, 7, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 6, 32'h7FFF_FFFF, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 7, 32'h8000_0000, $urandom_range(0, 17));
        add_cmd(sspq_pkg::KIND_ENQ, 32'h5555_5555, 32'h5555_5555, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 8, 1, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 9, -2, $urandom_range(0, 17));
        add_cmd(sspq_pkg::KIND_ENQ, 10, 100, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 11, 7, 0);
        // full: both of these are dropped
        add_cmd(sspq_pkg::KIND_ENQ, 12, -5, 0);
        add_cmd(sspq_pkg::KIND_ENQ, 32'h0000_FFFF, 32'h8000_0000, 0);
        repeat (5)
            add_cmd(sspq_pkg::KIND_DEQ, $urandom, $urandom, $urandom_range(0, 3));

        // random bursts that swing the occupancy between empty and full
        generated = 0;
        while (generated < 900)
        begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       enq_pct = 15;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            idle_mode = $urandom_range(0, 2);
            repeat (burst_len)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: w = sspq_pkg::word_t'(int'($urandom_range(0, 7)) - 4);
                    4, 5:
                    begin
                        case ($urandom_range(0, 3))
                            0:       w = 32'h8000_0000;
                            1:       w = 32'h7FFF_FFFF;
                            2:       w = 0;
                            default: w = -1;
                        endcase
                    end
                    default: w = $urandom;
                endcase
                case (idle_mode)
                    0:       gap = 0;
                    1:       gap = $urandom_range(0, 17);
                    default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                endcase
                add_cmd(($urandom_range(0, 99) < enq_pct) ? sspq_pkg::KIND_ENQ
                                                          : sspq_pkg::KIND_DEQ,
                        $urandom, w, gap);
                generated++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // drain: all words taken, every result seen, then a short tail
        @(negedge clk);
        while (commands_pending.size() > 0 || staged_valid || start || outcomes_due.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (outcomes_due.size() != 0)
        begin
            $error("%0d expected result words never arrived", outcomes_due.size());
            failures++;
        end

        $display("Ran %0d enqueues (%0d dropped on full) and %0d dequeues (%0d on empty).",
                 n_enq, n_drop, n_deq, n_empty_deq);
        $display("Checked %0d result words; peak occupancy %0d of %0d.",
                 results_checked, peak_count, CAPACITY);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== stable_sorted_priority_queue_unit.f =====
rtl/sspq_pkg.sv
rtl/sspq_cell.sv
rtl/stable_sorted_priority_queue_unit.sv
tb/sv/stable_sorted_priority_queue_unit_test.sv
